@@ src/swr_pkg.sv @@
// shared constants, register codes and control structs for the sample-without-replacement block
package swr_pkg;

    // payload widths fixed by the item format
    localparam int VALUE_W   = 8;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(WORD_W);

    // default pool capacity
    localparam int MAX_POOL_DEF = 256;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_LIMIT = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] POOL_SIZE_RST  = 9'd256;
    localparam logic [CFG_W-1:0] DRAW_LIMIT_RST = 9'd256;

    // request kinds
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_DRAW    = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic restart;
        logic mark_err;
        logic div_start;
        logic sweep_wr;
        logic rd_pick;
        logic rd_tail;
        logic commit;
        logic res_load;
    } swr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic restart_empty;
        logic draw_err;
        logic sweep_last;
        logic div_done;
        logic out_free;
    } swr_status_t;

endpackage

@@ src/swr_item_if.sv @@
// request channel: kind and random word
interface swr_item_if import swr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] random_word;

    modport source (output valid, output kind, output random_word, input ready);
    modport sink   (input valid, input kind, input random_word, output ready);
endinterface

@@ src/swr_result_if.sv @@
// result channel: drawn value and flags
interface swr_result_if import swr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               error;
    logic               last_draw;

    modport source (output valid, output value, output error, output last_draw, input ready);
    modport sink   (input valid, input value, input error, input last_draw, output ready);
endinterface

@@ src/swr_cfg_if.sv @@
// configuration write channel: register index and data
interface swr_cfg_if import swr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/swr_ram.sv @@
// generic single-write, single-read ram with registered read data
module swr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/swr_mod.sv @@
// bit-serial remainder unit: 32-bit word modulo a narrow divisor, one bit a cycle
module swr_mod import swr_pkg::*; #(
    parameter int CNT_W = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  rem
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [WORD_W-1:0] quot_reg;
    logic [WORD_W-1:0] quot_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;

    // one restoring step
    assign trial = {rem_reg, quot_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign done  = busy_reg && (cnt_reg == STEP_W'(WORD_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            rem_next  = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_next  = cnt_reg + STEP_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rem = rem_reg;

    // the finished remainder is below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(done) |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

endmodule

@@ src/swr_dp.sv @@
// datapath: registers, pool counters, slot ram, remainder unit and result registers
module swr_dp import swr_pkg::*; #(
    parameter int MAX_POOL = MAX_POOL_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swr_cmd_t             cmd,
    output swr_status_t          st,
    input  logic [WORD_W-1:0]    word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VALUE_W-1:0]   out_value,
    output logic                 out_error,
    output logic                 out_last
);

    localparam int IDX_W = $clog2(MAX_POOL);
    localparam int CNT_W = $clog2(MAX_POOL + 1);

    logic [CFG_W-1:0]   pool_size_reg;
    logic [CFG_W-1:0]   draw_limit_reg;
    logic [CNT_W-1:0]   remaining_reg;
    logic [CFG_W-1:0]   drawn_reg;
    logic [CNT_W-1:0]   sweep_cnt_reg;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   picked_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic               res_error_reg;
    logic               res_last_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_error_reg;
    logic               out_last_reg;

    logic [CNT_W-1:0]         pool_cap;
    logic [CNT_W-1:0]         remaining_dec;
    logic [IDX_W-1:0]         tail_addr;
    logic [CFG_W-1:0]         drawn_inc;
    logic [CNT_W-1:0]         div_rem;
    logic                     div_done;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [IDX_W:0]           ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [IDX_W:0]           ram_rdata;
    logic [IDX_W-1:0]         pick_val;
    logic [IDX_W-1:0]         tail_val;
    logic [VALUE_W+IDX_W-1:0] picked_ext;

    // pool size saturated at the capacity
    assign pool_cap = (32'(pool_size_reg) > 32'(MAX_POOL)) ? CNT_W'(MAX_POOL)
                                                           : CNT_W'(pool_size_reg);
    assign remaining_dec = remaining_reg - CNT_W'(1);
    assign tail_addr     = remaining_dec[IDX_W-1:0];
    assign drawn_inc     = drawn_reg + CFG_W'(1);

    // status
    assign st.restart_empty = (pool_cap == '0);
    assign st.draw_err      = (remaining_reg == '0) || (drawn_reg >= draw_limit_reg);
    assign st.sweep_last    = (sweep_cnt_reg == remaining_dec);
    assign st.div_done      = div_done;
    assign st.out_free      = !out_valid_reg || out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg  <= POOL_SIZE_RST;
            draw_limit_reg <= DRAW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_SIZE:  pool_size_reg  <= cfg_data;
                REG_DRAW_LIMIT: draw_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // remainder unit
    swr_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (word),
        .divisor  (remaining_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // slot ram: written flag above the stored index
    assign ram_we    = cmd.sweep_wr || cmd.commit;
    assign ram_waddr = cmd.commit ? r_reg : sweep_cnt_reg[IDX_W-1:0];
    assign ram_wdata = cmd.commit ? {1'b1, tail_val} : '0;
    assign ram_raddr = cmd.rd_tail ? tail_addr : div_rem[IDX_W-1:0];

    swr_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (MAX_POOL)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_pick || cmd.rd_tail),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // unwritten slots read as their own index
    assign pick_val   = ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : r_reg;
    assign tail_val   = ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : tail_addr;
    assign picked_ext = {{VALUE_W{1'b0}}, picked_reg};

    // pool counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            drawn_reg     <= '0;
            sweep_cnt_reg <= '0;
        end
        else if (cmd.restart)
        begin
            remaining_reg <= pool_cap;
            drawn_reg     <= '0;
            sweep_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            remaining_reg <= remaining_dec;
            drawn_reg     <= drawn_inc;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + CNT_W'(1);
        end
    end

    // drawn slot and picked value
    always_ff @(posedge clk)
    begin
        if (cmd.rd_pick)
        begin
            r_reg <= div_rem[IDX_W-1:0];
        end
        if (cmd.rd_tail)
        begin
            picked_reg <= pick_val;
        end
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.restart)
        begin
            res_value_reg <= '0;
            res_error_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else if (cmd.mark_err)
        begin
            res_value_reg <= '0;
            res_error_reg <= 1'b1;
            res_last_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_value_reg <= picked_ext[VALUE_W-1:0];
            res_error_reg <= 1'b0;
            res_last_reg  <= (drawn_inc == draw_limit_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_value_reg <= res_value_reg;
            out_error_reg <= res_error_reg;
            out_last_reg  <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_error = out_error_reg;
    assign out_last  = out_last_reg;

    // a committed draw always has a live pool and draws left
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (remaining_reg != '0) && (drawn_reg < draw_limit_reg))
        else $error("draw committed on empty pool or past limit");

    // the clearing sweep stays inside the live pool
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_wr |-> (sweep_cnt_reg < remaining_reg))
        else $error("sweep beyond live pool");

endmodule

@@ src/swr_ctrl.sv @@
// controller: sequences restart sweep, draw steps and result hand-off
module swr_ctrl import swr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    output swr_cmd_t    cmd,
    input  swr_status_t st
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SWEEP   = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_RD_PICK = 3'd3;
    localparam logic [2:0] S_RD_TAIL = 3'd4;
    localparam logic [2:0] S_COMMIT  = 3'd5;
    localparam logic [2:0] S_PUSH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_RESTART)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = st.restart_empty ? S_PUSH : S_SWEEP;
                    end
                    else if (st.draw_err)
                    begin
                        cmd.mark_err = 1'b1;
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_PUSH;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_RD_PICK;
                end
            end
            S_RD_PICK:
            begin
                cmd.rd_pick = 1'b1;
                state_next  = S_RD_TAIL;
            end
            S_RD_TAIL:
            begin
                cmd.rd_tail = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> st.out_free)
        else $error("result loaded over pending output");

endmodule

@@ src/sample_without_replacement.sv @@
// top level: partial shuffle sampler of distinct pool indices
//
//  channel  dir  payload                    handshake
//  item     in   kind, random_word          valid / ready
//  result   out  value, error, last_draw    valid / ready
//  cfg      in   index, data                valid / ready (ready held high)
//
// a draw passes the random word through the remainder unit, one bit a cycle, then does
// a slot read, a tail read, the write-back and the load of the output register.
// a restart clears the written flag of each live pool entry in turn; a draw error goes
// straight to the load. the next request is taken while a result waits, but a
// result still waiting when the next one is ready holds the block in its last step.
// reset is asynchronous, active low; slot ram contents need no reset.
module sample_without_replacement import swr_pkg::*; #(
    parameter int MAX_POOL = MAX_POOL_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    swr_item_if.sink     item,
    swr_result_if.source result,
    swr_cfg_if.sink      cfg
);

    swr_cmd_t    cmd;
    swr_status_t st;
    logic        in_ready;

    assign item.ready = in_ready;
    assign cfg.ready  = 1'b1;

    // sequencer
    swr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .kind     (item.kind),
        .cmd      (cmd),
        .st       (st)
    );

    // datapath
    swr_dp #(
        .MAX_POOL (MAX_POOL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .word      (item.random_word),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_value (result.value),
        .out_error (result.error),
        .out_last  (result.last_draw)
    );

endmodule

@@ tb/swr_checker.sv @@
// checker for the sample-without-replacement block: watches all channels, predicts and compares results
module swr_checker import swr_pkg::*; #(
    parameter int MAX_POOL = MAX_POOL_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    swr_item_if   item,
    swr_result_if result,
    swr_cfg_if    cfg,
    output int    fail_count,
    output int    pending,
    output int    checked,
    output int    err_flags,
    output int    last_flags
);

    localparam int IDX_W = $clog2(MAX_POOL);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               error;
        logic               last_draw;
    } draw_res_t;

    // shadow copy of the pool and the registers
    logic [VALUE_W-1:0] slot_val [MAX_POOL];
    logic               slot_set [MAX_POOL];
    logic [CFG_W-1:0]   live_cnt;
    logic [CFG_W-1:0]   draws_done;
    logic [CFG_W-1:0]   pool_cfg;
    logic [CFG_W-1:0]   limit_cfg;

    draw_res_t due_results [$];
    draw_res_t want;
    int        fails;
    int        n_checked;
    int        n_err;
    int        n_last;

    // one request applied to the shadow pool, giving the result it should produce
    function automatic draw_res_t draw_from_pool(input logic k, input logic [WORD_W-1:0] word);
        draw_res_t          res;
        logic [IDX_W-1:0]   pick_idx;
        logic [IDX_W-1:0]   tail_idx;
        logic [VALUE_W-1:0] picked;
        logic [VALUE_W-1:0] tail;
        res = '0;
        if (k == KIND_RESTART)
        begin
            // lazy refill: every slot reads as its own index again
            for (int i = 0; i < MAX_POOL; i++)
                slot_set[i] = 1'b0;
            live_cnt   = (pool_cfg > MAX_POOL) ? CFG_W'(MAX_POOL) : pool_cfg;
            draws_done = '0;
        end
        else if (live_cnt == 0 || draws_done >= limit_cfg)
        begin
            res.error = 1'b1;
        end
        else
        begin
            pick_idx = IDX_W'(word % WORD_W'(live_cnt));
            tail_idx = IDX_W'(live_cnt - CFG_W'(1));
            picked   = slot_set[pick_idx] ? slot_val[pick_idx] : VALUE_W'(pick_idx);
            tail     = slot_set[tail_idx] ? slot_val[tail_idx] : VALUE_W'(tail_idx);
            // move the last live slot into the hole
            slot_val[pick_idx] = tail;
            slot_set[pick_idx] = 1'b1;
            live_cnt   = live_cnt - CFG_W'(1);
            draws_done = draws_done + CFG_W'(1);
            res.value     = picked;
            res.last_draw = (draws_done == limit_cfg);
        end
        return res;
    endfunction

    // monitor: compare results first, then registers, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            for (int i = 0; i < MAX_POOL; i++)
                slot_set[i] = 1'b0;
            live_cnt   = '0;
            draws_done = '0;
            pool_cfg   = POOL_SIZE_RST;
            limit_cfg  = DRAW_LIMIT_RST;
            fails      = 0;
            n_checked  = 0;
            n_err      = 0;
            n_last     = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no request waiting: value %0d error %0d last_draw %0d",
                           result.value, result.error, result.last_draw);
                    fails++;
                end
                else
                begin
                    want = due_results.pop_front();
                    n_checked++;
                    if (want.error)
                        n_err++;
                    if (want.last_draw)
                        n_last++;
                    if (result.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, result.value);
                        fails++;
                    end
                    if (result.error !== want.error)
                    begin
                        $error("error: expected %0d, got %0d", want.error, result.error);
                        fails++;
                    end
                    if (result.last_draw !== want.last_draw)
                    begin
                        $error("last_draw: expected %0d, got %0d", want.last_draw,
                               result.last_draw);
                        fails++;
                    end
                end
            end

            // register writes; unknown indexes are dropped
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_POOL_SIZE)
                    pool_cfg = cfg.data;
                else if (cfg.index == REG_DRAW_LIMIT)
                    limit_cfg = cfg.data;
            end

            if (item.valid && item.ready)
                due_results.push_back(draw_from_pool(item.kind, item.random_word));
        end
        pending    <= due_results.size();
        fail_count <= fails;
        checked    <= n_checked;
        err_flags  <= n_err;
        last_flags <= n_last;
    end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the sample-without-replacement block: clock, reset, stimulus and verdict
module tb_top import swr_pkg::*; ();

    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 100;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    logic clk;
    logic rst_n;
    logic idle_en;

    int fail_cnt;
    int pend_cnt;
    int checked_cnt;
    int err_flag_cnt;
    int last_flag_cnt;
    int req_cnt;
    int setting_cnt;
    int phase_reqs;

    int unsigned      eff_pool;
    int unsigned      seq_len;
    int unsigned      cap;
    logic [CFG_W-1:0] pool_sel;
    logic [CFG_W-1:0] limit_sel;

    swr_item_if   item_ch ();
    swr_result_if res_ch ();
    swr_cfg_if    cfg_ch ();

    sample_without_replacement u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    swr_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (res_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_cnt),
        .pending    (pend_cnt),
        .checked    (checked_cnt),
        .err_flags  (err_flag_cnt),
        .last_flags (last_flag_cnt)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #40_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !idle_en || ($urandom_range(99) >= 28);
        end
    end

    // random word biased towards the edges
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'($urandom_range(511));
            default: return $urandom;
        endcase
    endfunction

    // one request, with random idle cycles in front; valid stays up for the next one
    task automatic send_req(input logic k, input logic [WORD_W-1:0] w);
        if (idle_en)
            while ($urandom_range(99) < 28)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= k;
        item_ch.random_word <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        req_cnt++;
    endtask

    // stop sending and wait until every result is back and the block is quiet
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pend_cnt != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_RESTART;
        item_ch.random_word <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_POOL_SIZE;
        cfg_ch.data         <= '0;
        idle_en             <= 1'b1;
        rst_n               <= 1'b0;
        req_cnt     = 0;
        setting_cnt = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws before any restart
        send_req(KIND_DRAW, '0);
        send_req(KIND_DRAW, '1);

        // three-entry pool drawn past empty
        settle();
        write_reg(REG_POOL_SIZE, 9'd3);
        setting_cnt++;
        send_req(KIND_RESTART, '1);
        send_req(KIND_DRAW, '0);
        send_req(KIND_DRAW, '1);
        send_req(KIND_DRAW, 32'h8000_0000);
        send_req(KIND_DRAW, 32'h1234_5678);

        // oversize pool saturates, draw limit of two
        settle();
        write_reg(REG_POOL_SIZE, 9'h1FF);
        write_reg(REG_DRAW_LIMIT, 9'd2);
        setting_cnt++;
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, '1);
        send_req(KIND_DRAW, 32'h5555_5555);
        send_req(KIND_DRAW, 32'hAAAA_AAAA);

        // empty pool
        settle();
        write_reg(REG_POOL_SIZE, 9'd0);
        write_reg(REG_DRAW_LIMIT, 9'd256);
        setting_cnt++;
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, 32'h0000_0007);

        // zero draw limit, writes to unmapped indexes dropped
        settle();
        write_reg(REG_POOL_SIZE, 9'd5);
        write_reg(REG_DRAW_LIMIT, 9'd0);
        write_reg(REG_UNUSED_A, 9'h1FF);
        write_reg(REG_UNUSED_B, 9'h1FF);
        setting_cnt++;
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, 32'h0000_0003);

        // single entry, single draw
        settle();
        write_reg(REG_POOL_SIZE, 9'd1);
        write_reg(REG_DRAW_LIMIT, 9'd1);
        setting_cnt++;
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, '1);
        send_req(KIND_DRAW, '1);

        // new pool size only counts from the next restart
        settle();
        write_reg(REG_POOL_SIZE, 9'd4);
        write_reg(REG_DRAW_LIMIT, 9'h1FF);
        setting_cnt++;
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, 32'h0000_0002);
        settle();
        write_reg(REG_POOL_SIZE, 9'd200);
        setting_cnt++;
        send_req(KIND_DRAW, '1);
        send_req(KIND_DRAW, 32'h0000_0001);
        send_req(KIND_RESTART, '0);
        send_req(KIND_DRAW, '1);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    pool_sel  = 9'd256;
                    limit_sel = 9'd256;
                end
                1:
                begin
                    pool_sel  = 9'd1;
                    limit_sel = 9'h1FF;
                end
                2:
                begin
                    pool_sel  = 9'h1FF;
                    limit_sel = 9'd0;
                end
                default:
                begin
                    case ($urandom_range(4))
                        0:       pool_sel = 9'd256;
                        1:       pool_sel = CFG_W'($urandom_range(1, 16));
                        2:       pool_sel = CFG_W'($urandom_range(17, 255));
                        3:       pool_sel = CFG_W'($urandom_range(257, 511));
                        default: pool_sel = CFG_W'($urandom_range(0, 8));
                    endcase
                    case ($urandom_range(4))
                        0:       limit_sel = 9'd0;
                        1:       limit_sel = 9'd256;
                        2:       limit_sel = 9'h1FF;
                        3:       limit_sel = CFG_W'($urandom_range(1, 40));
                        default: limit_sel = CFG_W'($urandom_range(0, 511));
                    endcase
                end
            endcase
            write_reg(REG_POOL_SIZE, pool_sel);
            write_reg(REG_DRAW_LIMIT, limit_sel);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
                          CFG_W'($urandom));
            setting_cnt++;

            // in phases 4 and 5, a long stretch with both sides running flat out
            idle_en  <= !(ph == 4 || ph == 5);
            eff_pool = (pool_sel > MAX_POOL_DEF) ? MAX_POOL_DEF : pool_sel;
            cap      = (eff_pool + 2 < 40) ? eff_pool + 2 : 40;

            phase_reqs = 0;
            while (phase_reqs < PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 8)
                begin
                    // restart followed by a run of draws, sometimes past the end of the pool
                    send_req(KIND_RESTART, $urandom);
                    phase_reqs++;
                    seq_len = ($urandom_range(5) == 0) ? eff_pool + 2 : $urandom_range(1, cap);
                    repeat (seq_len)
                    begin
                        send_req(KIND_DRAW, pick_word());
                        phase_reqs++;
                    end
                end
                else
                begin
                    send_req($urandom_range(1) ? KIND_DRAW : KIND_RESTART, pick_word());
                    phase_reqs++;
                end
            end
        end

        settle();
        $display("run covered %0d requests over %0d register settings", req_cnt, setting_cnt);
        $display("%0d results checked, %0d with error flag, %0d ending on the draw limit",
                 checked_cnt, err_flag_cnt, last_flag_cnt);
        if (fail_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/swr_pkg.sv
src/swr_item_if.sv
src/swr_result_if.sv
src/swr_cfg_if.sv
src/swr_ram.sv
src/swr_mod.sv
src/swr_dp.sv
src/swr_ctrl.sv
src/sample_without_replacement.sv
tb/swr_checker.sv
tb/tb_top.sv
